[hw/rtl/pca_pkg.sv]
// Shared constants and types for the pairwise co-association ratio block.
package pca_pkg;

    localparam int MAX_OBSERVATIONS_DEF = 256;
    localparam int MAX_SUBSAMPLES_DEF   = 128;

    localparam int OBS_W     = 8;
    localparam int SUB_IN_W  = 7;
    localparam int LABEL_W   = 16;
    localparam int ENTRY_W   = LABEL_W + 1;
    localparam int FRAC_W    = 16;
    localparam int PROP_W    = FRAC_W + 1;
    localparam int COUNT_W   = 8;
    localparam int CFG_W     = 8;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic REG_SUBSAMPLES_IN_USE = 1'b0;

    localparam logic [CFG_W-1:0] SUBSAMPLES_RESET = 8'd128;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[hw/rtl/pairwise_coassociation_ratio.sv]
// Top level: label store, pair scan sequencer, divider, APB register.
// Write item: no result; the input side stays ready.
// Query below the diagonal: one label pair per cycle up to limit (saturated subsamples_in_use),
// then 17 divider steps and the output load; with no valid pair the divide is skipped. Other
// queries go straight to the output load. One query at a time.
// Reset: async active low; control cleared, subsamples_in_use = 128, store not cleared.
module pairwise_coassociation_ratio #(
    parameter int MAX_OBSERVATIONS = pca_pkg::MAX_OBSERVATIONS_DEF,
    parameter int MAX_SUBSAMPLES   = pca_pkg::MAX_SUBSAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // first_obs[7:0], second_obs[15:8], subsample_index[22:16], label[38:23], pad
    input  logic [pca_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind[0], label_missing[1]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // proportion[16:0], match_count[24:17], valid_count[32:25], pad
    output logic [pca_pkg::OUT_DATA_W-1:0]  m_tdata,
    // undefined[0]
    output logic                            m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pca_pkg::PADDR_W-1:0]     paddr,
    input  logic [pca_pkg::APB_W-1:0]       pwdata,
    output logic [pca_pkg::APB_W-1:0]       prdata,
    output logic                            pready
);

    localparam int OBS_IW  = (MAX_OBSERVATIONS > 1) ? $clog2(MAX_OBSERVATIONS) : 1;
    localparam int SUB_IW  = (MAX_SUBSAMPLES > 1) ? $clog2(MAX_SUBSAMPLES) : 1;
    localparam int CNT_W   = $clog2(MAX_SUBSAMPLES + 1);
    localparam int AW      = OBS_IW + SUB_IW;
    localparam int OBS_SPAN = 1 << pca_pkg::OBS_W;

    function automatic logic [OBS_SPAN-1:0][OBS_IW-1:0] build_obs_map();
        logic [OBS_SPAN-1:0][OBS_IW-1:0] t;
        int r;
        r = 0;
        for (int k = 0; k < OBS_SPAN; k++)
        begin
            t[k] = OBS_IW'(r);
            r = (r + 1 == MAX_OBSERVATIONS) ? 0 : r + 1;
        end
        return t;
    endfunction

    localparam logic [OBS_SPAN-1:0][OBS_IW-1:0] OBS_MAP = build_obs_map();

    pca_pkg::state_t state_reg, state_next;

    logic [pca_pkg::CFG_W-1:0]  sub_in_use_reg;
    logic [OBS_IW-1:0]          i_reg, j_reg;
    logic [CNT_W-1:0]           issue_reg;
    logic                       pend_reg;
    logic [CNT_W-1:0]           match_reg, valid_reg;
    logic                       skip_reg;
    logic                       m_tvalid_reg;
    logic [pca_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                       m_tuser_reg;

    logic                       s_acc;
    logic                       in_kind;
    logic                       in_missing;
    logic [OBS_IW-1:0]          in_i, in_j;
    logic [pca_pkg::SUB_IN_W-1:0] in_sub;
    logic [pca_pkg::LABEL_W-1:0] in_label;
    logic [CNT_W-1:0]           limit;
    logic                       issuing;
    logic                       scan_done;
    logic                       div_start;
    logic                       load_out;
    logic                       ready_c;
    logic                       mem_we;
    logic [AW-1:0]              raddr_a, raddr_b;
    logic [pca_pkg::ENTRY_W-1:0] rdata_a, rdata_b;
    logic                       both_present;
    logic                       labels_equal;
    logic [pca_pkg::PROP_W-1:0] quotient;
    pca_pkg::div_status_t       div_st;
    logic                       cfg_wr;
    logic                       no_valid;

    assign in_kind    = s_tuser[0];
    assign in_missing = s_tuser[1];
    assign in_i       = OBS_MAP[s_tdata[7:0]];
    assign in_j       = OBS_MAP[s_tdata[15:8]];
    assign in_sub     = s_tdata[22:16];
    assign in_label   = s_tdata[38:23];

    assign s_acc = s_tvalid && ready_c;

    always_comb
    begin
        if (32'(sub_in_use_reg) > 32'(MAX_SUBSAMPLES))
        begin
            limit = CNT_W'(MAX_SUBSAMPLES);
        end
        else
        begin
            limit = CNT_W'(sub_in_use_reg);
        end
    end

    assign no_valid  = (valid_reg == '0);
    assign scan_done = !issuing && !pend_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pca_pkg::ST_IDLE:
            begin
                if (s_acc && (in_kind == pca_pkg::KIND_QUERY))
                begin
                    state_next = (in_i > in_j) ? pca_pkg::ST_SCAN : pca_pkg::ST_DONE;
                end
            end
            pca_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = no_valid ? pca_pkg::ST_DONE : pca_pkg::ST_DIV;
                end
            end
            pca_pkg::ST_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = pca_pkg::ST_DONE;
                end
            end
            pca_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = pca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pca_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        ready_c  = 1'b0;
        issuing  = 1'b0;
        div_start = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            pca_pkg::ST_IDLE:
            begin
                ready_c = 1'b1;
            end
            pca_pkg::ST_SCAN:
            begin
                issuing   = (issue_reg < limit);
                div_start = !(issue_reg < limit) && !pend_reg && !no_valid;
            end
            pca_pkg::ST_DIV:
            begin
                ready_c = 1'b0;
            end
            pca_pkg::ST_DONE:
            begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                ready_c = 1'b0;
            end
        endcase
    end

    assign mem_we = s_acc && (in_kind == pca_pkg::KIND_WRITE)
                    && (32'(in_sub) < 32'(MAX_SUBSAMPLES));
    assign raddr_a = {i_reg, issue_reg[SUB_IW-1:0]};
    assign raddr_b = {j_reg, issue_reg[SUB_IW-1:0]};

    pca_label_mem #(
        .AW(AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   ({in_i, SUB_IW'(in_sub)}),
        .wdata   ({in_missing, in_label}),
        .re      (issuing),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign both_present = !rdata_a[pca_pkg::LABEL_W] && !rdata_b[pca_pkg::LABEL_W];
    assign labels_equal = (rdata_a[pca_pkg::LABEL_W-1:0] == rdata_b[pca_pkg::LABEL_W-1:0]);

    pca_div #(
        .CNT_W(CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (match_reg),
        .divisor  (valid_reg),
        .quotient (quotient),
        .status   (div_st)
    );

    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == pca_pkg::REG_SUBSAMPLES_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pca_pkg::ST_IDLE;
            sub_in_use_reg <= pca_pkg::SUBSAMPLES_RESET;
            pend_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issuing;
            if (cfg_wr)
            begin
                sub_in_use_reg <= pwdata[pca_pkg::CFG_W-1:0];
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc && (in_kind == pca_pkg::KIND_QUERY))
        begin
            i_reg     <= in_i;
            j_reg     <= in_j;
            issue_reg <= '0;
            match_reg <= '0;
            valid_reg <= '0;
            skip_reg  <= !(in_i > in_j);
        end
        else
        begin
            if (issuing)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (pend_reg && both_present)
            begin
                valid_reg <= valid_reg + 1'b1;
                if (labels_equal)
                begin
                    match_reg <= match_reg + 1'b1;
                end
            end
        end
        if (load_out)
        begin
            m_tdata_reg <= {7'b0,
                            pca_pkg::COUNT_W'(valid_reg),
                            pca_pkg::COUNT_W'(match_reg),
                            no_valid ? '0 : quotient};
            m_tuser_reg <= !skip_reg && no_valid;
        end
    end

    assign s_tready = ready_c;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == pca_pkg::REG_SUBSAMPLES_IN_USE)
                      ? pca_pkg::APB_W'(sub_in_use_reg) : '0;

endmodule

[hw/rtl/pca_label_mem.sv]
// Label store: one write port, two registered read ports.
module pca_label_mem #(
    parameter int AW = 15
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [pca_pkg::ENTRY_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr_a,
    input  logic [AW-1:0]               raddr_b,
    output logic [pca_pkg::ENTRY_W-1:0] rdata_a,
    output logic [pca_pkg::ENTRY_W-1:0] rdata_b
);

    logic [pca_pkg::ENTRY_W-1:0] mem [(1 << AW)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

[hw/rtl/pca_div.sv]
// Restoring divider, one quotient bit per cycle: (match << 16) / valid, match <= valid.
module pca_div #(
    parameter int CNT_W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [CNT_W-1:0]           dividend,
    input  logic [CNT_W-1:0]           divisor,
    output logic [pca_pkg::PROP_W-1:0] quotient,
    output pca_pkg::div_status_t       status
);

    localparam int STEP_W = $clog2(pca_pkg::PROP_W);

    logic                       busy_reg, busy_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [CNT_W:0]             rem_reg, rem_next;
    logic [CNT_W-1:0]           den_reg, den_next;
    logic [pca_pkg::PROP_W-1:0] quo_reg, quo_next;
    logic                       last;
    logic                       ge;
    logic [CNT_W:0]             diff;
    logic [CNT_W:0]             kept;

    assign last = busy_reg && (step_reg == STEP_W'(pca_pkg::PROP_W - 1));
    assign diff = rem_reg - {1'b0, den_reg};
    assign ge   = (rem_reg >= {1'b0, den_reg});
    assign kept = ge ? diff : rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = {1'b0, dividend};
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[pca_pkg::PROP_W-2:0], ge};
            rem_next  = {kept[CNT_W-1:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = last;

endmodule

[hw/rtl/pca_checker.sv]
// Port-level checks for the pairwise co-association ratio block, bound to the top level.
module pca_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [pca_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic [1:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pca_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    // a query blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == pca_pkg::KIND_QUERY)) |=> !s_tready)
        else $error("input still ready after query accept");

    // a new result only follows a busy input side
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without a query in flight");

    // undefined result carries zero ratio and counts
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[32:0] == '0))
        else $error("undefined result with nonzero fields");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind pairwise_coassociation_ratio pca_checker u_pca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
